@@ design/assert_macros.svh @@
// assertion macros shared by the indexed list design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ILST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define ILST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ilst_pkg.sv @@
// constants, codes and types of the indexed list
package ilst_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam int OPC_W  = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int ECNT_W = 7;
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [OPC_W-1:0] OP_INSERT = OPC_W'(0);
  localparam logic [OPC_W-1:0] OP_REMOVE = OPC_W'(1);
  localparam logic [OPC_W-1:0] OP_READ   = OPC_W'(2);

  localparam logic [STAT_W-1:0] ST_DONE  = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_RANGE = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_FULL  = STAT_W'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_PUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [ECNT_W-1:0]       entry_count;
  } result_t;

  typedef struct packed {
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [ADDR_W-1:0]     rd_addr;
  } mem_req_t;

  // stored word from a value field: keep the low bits
  function automatic logic [DATA_WIDTH-1:0] to_data(input logic [VAL_W-1:0] v);
    logic [DATA_WIDTH+VAL_W-1:0] tmp;
    tmp = {{DATA_WIDTH{1'b0}}, v};
    return tmp[DATA_WIDTH-1:0];
  endfunction

  // value field from a stored word: low bits, zero filled
  function automatic logic [VAL_W-1:0] to_val(input logic [DATA_WIDTH-1:0] d);
    logic [DATA_WIDTH+VAL_W-1:0] tmp;
    tmp = {{VAL_W{1'b0}}, d};
    return tmp[VAL_W-1:0];
  endfunction

endpackage

@@ design/ilst_if.sv @@
// valid/ready channels for list requests and results
interface ilst_in_if;
  logic                             valid;
  logic                             ready;
  logic [ilst_pkg::OPC_W-1:0]       opcode;
  logic [ilst_pkg::POS_W-1:0]       position;
  logic signed [ilst_pkg::VAL_W-1:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink (input valid, input opcode, input position, input value, output ready);
endinterface

interface ilst_out_if;
  logic                              valid;
  logic                              ready;
  logic [ilst_pkg::STAT_W-1:0]       status;
  logic signed [ilst_pkg::VAL_W-1:0] read_value;
  logic [ilst_pkg::ECNT_W-1:0]       entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input read_value, input entry_count,
                output ready);
endinterface

@@ design/ilst_store.sv @@
// entry store: one write port, one registered read port
module ilst_store (
  input  logic                               clk,
  input  ilst_pkg::mem_req_t                 mem_req,
  output logic [ilst_pkg::DATA_WIDTH-1:0]    rd_data
);

  logic [ilst_pkg::DATA_WIDTH-1:0] mem [ilst_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    rd_data <= mem[mem_req.rd_addr];
  end

endmodule

@@ design/ilst_ctrl.sv @@
// sequencer and shared index stepper that moves entries one at a time
`include "assert_macros.svh"

module ilst_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  ilst_pkg::item_t                 item,
  output logic                            ready,
  output logic                            res_valid,
  input  logic                            res_take,
  output ilst_pkg::result_t               res,
  output ilst_pkg::mem_req_t              mem_req,
  input  logic [ilst_pkg::DATA_WIDTH-1:0] mem_rdata
);

  localparam int CNT_W  = ilst_pkg::CNT_W;
  localparam int ADDR_W = ilst_pkg::ADDR_W;
  localparam int CMP_W  = ilst_pkg::CMP_W;

  ilst_pkg::state_t state, state_next;

  logic [ilst_pkg::OPC_W-1:0]      op;
  logic [ilst_pkg::DATA_WIDTH-1:0] val;
  logic [ADDR_W-1:0]               idx;
  logic [ADDR_W-1:0]               stop;
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                count_after;
  logic [ilst_pkg::STAT_W-1:0]     status;
  logic [ilst_pkg::VAL_W-1:0]      rd;
  logic                            grow;
  logic                            shrink;

  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  cnt_w;
  logic              pos_gt;
  logic              pos_ge;
  logic              pos_eq;
  logic              pos_last;
  logic              full;
  logic [ADDR_W-1:0] src;
  logic              arrived;

  logic [ilst_pkg::STAT_W-1:0] chk_status;
  logic                        chk_grow;
  logic                        chk_shrink;

  // request checks against the current count
  assign pos_w    = CMP_W'(item.position);
  assign cnt_w    = CMP_W'(count);
  assign pos_gt   = pos_w > cnt_w;
  assign pos_ge   = pos_w >= cnt_w;
  assign pos_eq   = pos_w == cnt_w;
  assign pos_last = CMP_W'(pos_w + CMP_W'(1)) == cnt_w;
  assign full     = count == CNT_W'(ilst_pkg::CAPACITY);

  // status of an incoming request, index checked before full
  always_comb begin
    chk_status = ilst_pkg::ST_DONE;
    case (item.opcode) inside
      ilst_pkg::OP_INSERT: begin
        if (pos_gt) begin
          chk_status = ilst_pkg::ST_RANGE;
        end else if (full) begin
          chk_status = ilst_pkg::ST_FULL;
        end
      end
      ilst_pkg::OP_REMOVE, ilst_pkg::OP_READ: begin
        if (pos_ge) begin
          chk_status = ilst_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  assign chk_grow   = (item.opcode == ilst_pkg::OP_INSERT) && !pos_gt && !full;
  assign chk_shrink = (item.opcode == ilst_pkg::OP_REMOVE) && !pos_ge;

  // shared stepper: next source slot and end test
  assign src     = (op == ilst_pkg::OP_INSERT) ? ADDR_W'(idx - ADDR_W'(1))
                                               : ADDR_W'(idx + ADDR_W'(1));
  assign arrived = src == stop;

  assign count_after = CNT_W'(count + CNT_W'(grow) - CNT_W'(shrink));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilst_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ilst_pkg::S_DONE && res_take) begin
        count <= count_after;
      end
    end
  end

  // operation registers
  always_ff @(posedge clk) begin
    unique case (state)
      ilst_pkg::S_IDLE: begin
        if (start) begin
          op     <= item.opcode;
          val    <= ilst_pkg::to_data(item.value);
          rd     <= '0;
          status <= chk_status;
          grow   <= chk_grow;
          shrink <= chk_shrink;
          // insert walks down from the top, the others up from the index
          if (item.opcode == ilst_pkg::OP_INSERT) begin
            idx  <= ADDR_W'(count);
            stop <= ADDR_W'(item.position);
          end else begin
            idx  <= ADDR_W'(item.position);
            stop <= ADDR_W'(count - CNT_W'(1));
          end
        end
      end
      ilst_pkg::S_WR: begin
        if (op == ilst_pkg::OP_READ) begin
          rd <= ilst_pkg::to_val(mem_rdata);
        end else begin
          idx <= src;
        end
      end
      ilst_pkg::S_RD, ilst_pkg::S_PUT, ilst_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ilst_pkg::S_IDLE: begin
        if (start) begin
          case (item.opcode)
            ilst_pkg::OP_INSERT: begin
              if (pos_gt || full) begin
                state_next = ilst_pkg::S_DONE;
              end else if (pos_eq) begin
                state_next = ilst_pkg::S_PUT;
              end else begin
                state_next = ilst_pkg::S_RD;
              end
            end
            ilst_pkg::OP_REMOVE: begin
              if (pos_ge || pos_last) begin
                state_next = ilst_pkg::S_DONE;
              end else begin
                state_next = ilst_pkg::S_RD;
              end
            end
            ilst_pkg::OP_READ: begin
              state_next = pos_ge ? ilst_pkg::S_DONE : ilst_pkg::S_RD;
            end
            default: state_next = ilst_pkg::S_DONE;
          endcase
        end
      end
      ilst_pkg::S_RD: state_next = ilst_pkg::S_WR;
      ilst_pkg::S_WR: begin
        if (op == ilst_pkg::OP_READ) begin
          state_next = ilst_pkg::S_DONE;
        end else if (!arrived) begin
          state_next = ilst_pkg::S_RD;
        end else if (op == ilst_pkg::OP_INSERT) begin
          state_next = ilst_pkg::S_PUT;
        end else begin
          state_next = ilst_pkg::S_DONE;
        end
      end
      ilst_pkg::S_PUT: state_next = ilst_pkg::S_DONE;
      ilst_pkg::S_DONE: begin
        if (res_take) begin
          state_next = ilst_pkg::S_IDLE;
        end
      end
      default: state_next = ilst_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ready             = 1'b0;
    res_valid         = 1'b0;
    mem_req.wr_en     = 1'b0;
    mem_req.wr_addr   = idx;
    mem_req.wr_data   = mem_rdata;
    mem_req.rd_addr   = (op == ilst_pkg::OP_READ) ? idx : src;
    res.status        = status;
    res.read_value    = rd;
    res.entry_count   = ilst_pkg::ECNT_W'(count_after);
    unique case (state)
      ilst_pkg::S_IDLE: ready = 1'b1;
      ilst_pkg::S_RD: begin
      end
      ilst_pkg::S_WR: mem_req.wr_en = (op != ilst_pkg::OP_READ);
      ilst_pkg::S_PUT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_data = val;
      end
      ilst_pkg::S_DONE: res_valid = 1'b1;
      default: begin
      end
    endcase
  end

  `ILST_ASSERT_RST(a_reset_clear, rst |=> (count == '0 && state == ilst_pkg::S_IDLE), "reset did not clear the list")
  `ILST_ASSERT(a_count_cap, count <= CNT_W'(ilst_pkg::CAPACITY), "count above capacity")
  `ILST_ASSERT(a_count_hold, !(res_valid && res_take) |=> $stable(count), "count moved without a result")
  `ILST_ASSERT(a_wr_in_list, mem_req.wr_en |-> CNT_W'(mem_req.wr_addr) <= count, "write beyond list end")
  `ILST_ASSERT(a_full_insert, (res_valid && res.status == ilst_pkg::ST_FULL) |-> op == ilst_pkg::OP_INSERT, "full status on non-insert")

endmodule

@@ design/indexed_list_insert_remove.sv @@
// insert moves the entries from the index up a slot, then puts the value; remove moves the
//   entries above the index down a slot; read fetches one entry; a rejected or unused
//   opcode goes straight to the result, registered at the output; no new item is taken
//   before a result moves on; each moved entry is one read then one write in the store
// reset: synchronous active-high rst empties the list and drops pending results;
//   store contents are not cleared, slots at or above the count are never read
module indexed_list_insert_remove (
  input  logic         clk,
  input  logic         rst,
  ilst_in_if.sink      req,
  ilst_out_if.source   rsp
);

  ilst_pkg::item_t    item;
  ilst_pkg::result_t  res;
  ilst_pkg::mem_req_t mem_req;

  logic [ilst_pkg::DATA_WIDTH-1:0] mem_rdata;
  logic                            ctrl_ready;
  logic                            start;
  logic                            res_valid;
  logic                            res_take;

  // output register
  logic                              out_valid;
  logic [ilst_pkg::STAT_W-1:0]       out_status;
  logic signed [ilst_pkg::VAL_W-1:0] out_read_value;
  logic [ilst_pkg::ECNT_W-1:0]       out_entry_count;

  // request beat goes straight into the sequencer when it is idle
  assign item.opcode   = req.opcode;
  assign item.position = req.position;
  assign item.value    = req.value;
  assign req.ready     = ctrl_ready;
  assign start         = req.valid && ctrl_ready;

  // a finished result moves on when the output register is empty or draining
  assign res_take = res_valid && (!out_valid || rsp.ready);

  ilst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .ready     (ctrl_ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  ilst_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (mem_rdata)
  );

  // result beat holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status      <= res.status;
      out_read_value  <= res.read_value;
      out_entry_count <= res.entry_count;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = out_read_value;
  assign rsp.entry_count = out_entry_count;

endmodule
